@@ hdl/bgps_pkg.sv @@
// Shared types, constants and table functions for the Bezier glow pixel shader.
// Used by every module of the block; depends on nothing.
package bgps_pkg;

	localparam int SAMPLE_COUNT_DEF = 256;
	localparam int WTAB_DEPTH_DEF   = 256;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_CP0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CP3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR = 3'd4;

	// Running minimum starts at 1.0 in Q0.32
	localparam logic [32:0] BEST_INIT = 33'h1_0000_0000;
	localparam logic [16:0] ONE_Q16   = 17'h10000;
	localparam logic [23:0] OUT_SCALE = 24'd16777150;

	// Per channel background level and gain: red, green, blue
	localparam logic [13:0] BG_LEVEL [0:2] = '{14'd3277, 14'd3277, 14'd9830};
	localparam logic [16:0] GAIN     [0:2] = '{17'd65536, 17'd78643, 17'd98304};

	// Pixel moving down the cell chain
	typedef struct packed {
		logic        valid;
		logic [15:0] px;
		logic [15:0] py;
		logic [32:0] best;
	} pix_t;

	// Sample load from the builder into the head of the chain
	typedef struct packed {
		logic        load;
		logic [31:0] sample;
	} smp_load_t;

	// Divide by a small loop count (1 to 8)
	function automatic longint unsigned div_small(longint unsigned v, int unsigned n);
		longint unsigned q;
		case (n)
			1: q = v;
			2: q = v / 2;
			3: q = v / 3;
			4: q = v / 4;
			5: q = v / 5;
			6: q = v / 6;
			7: q = v / 7;
			8: q = v / 8;
			default: q = v;
		endcase
		return q;
	endfunction

	// Ratio between neighboring weight entries, Q32
	function automatic longint unsigned wrom_ratio(longint unsigned step);
		longint unsigned s;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned r;
		s    = step >> 4;
		term = 64'h1_0000_0000;
		sum  = 64'h1_0000_0000;
		for (int unsigned n = 1; n <= 8; n++) begin
			term = div_small((term * s) >> 32, n);
			if (n[0]) sum = sum - term;
			else sum = sum + term;
		end
		r = sum;
		for (int n = 0; n < 4; n++)
			r = (r * r + 64'h8000_0000) >> 32;
		return r;
	endfunction

	// Weight entry k, Q16 with 1.0 = 65536
	function automatic logic [16:0] wrom_entry(int unsigned k, longint unsigned r);
		longint unsigned acc;
		acc = 64'h1_0000_0000;
		for (int unsigned m = 0; m < k; m++)
			acc = (acc * r + 64'h8000_0000) >> 32;
		return 17'((acc + 64'd32768) >> 16);
	endfunction

endpackage

@@ hdl/bezier_glow_pixel_shader.sv @@
// Top level of the Bezier glow pixel shader: config registers, sample builder,
// chain of distance cells and shading pipeline. Depends on bgps_pkg, bgps_build,
// bgps_cell and bgps_shade.
//
//   Channel   Direction  Handshake          Payload
//   s_axis    in         s_tvalid/s_tready  s_tdata: pixel_x, pixel_y
//   m_axis    out        m_tvalid/m_tready  m_tdata: red, green, blue
//   cfg       in         cfg_valid/ready    cfg_index, cfg_data
//
// A pixel is accepted every cycle once the samples are built and the output is
// not stalled; the chain has two register stages per sample cell.
// After reset or a control point write, the builder computes every sample
// (four multiply-accumulate steps per coordinate, reciprocal divide with one
// compare and subtract step) before s_tready rises.
// A stalled output holds the whole chain; cfg_ready is always high.
module bezier_glow_pixel_shader import bgps_pkg::*; #(
	parameter int SAMPLE_COUNT       = SAMPLE_COUNT_DEF,
	parameter int WEIGHT_TABLE_DEPTH = WTAB_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,   // pixel_x [15:0], pixel_y [31:16]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // red [7:0], green [15:8], blue [23:16]
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [47:0]          cfg_data
);

	logic [3:0][31:0] cp_q;
	logic [47:0]      color_q;
	logic             restart;
	logic             samples_ready;
	logic             adv;
	smp_load_t        smp;
	pix_t             chain [SAMPLE_COUNT+1];
	logic [31:0]      smp_chain [SAMPLE_COUNT];

	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid && (cfg_index inside {[REG_CP0:REG_CP3]});

	// Take configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q    <= '0;
			color_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index inside {[REG_CP0:REG_CP3]}) cp_q[cfg_index[1:0]] <= cfg_data[31:0];
			else if (cfg_index == REG_COLOR) color_q <= cfg_data;
		end
	end

	bgps_build #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_build (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.cp      (cp_q),
		.smp     (smp),
		.ready   (samples_ready)
	);

	// Advance everything when the output register is free or drained
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = samples_ready && adv;

	assign chain[0].valid = s_tvalid && s_tready;
	assign chain[0].px    = s_tdata[15:0];
	assign chain[0].py    = s_tdata[31:16];
	assign chain[0].best  = BEST_INIT;
	assign smp_chain[0]   = smp.sample;

	for (genvar k = 0; k < SAMPLE_COUNT; k++) begin : g_cell
		if (k < SAMPLE_COUNT - 1) begin : g_mid
			bgps_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.load   (smp.load),
				.smp_i  (smp_chain[k]),
				.smp_o  (smp_chain[k+1]),
				.pix_i  (chain[k]),
				.pix_o  (chain[k+1])
			);
		end else begin : g_last
			bgps_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.load   (smp.load),
				.smp_i  (smp_chain[k]),
				.smp_o  (),
				.pix_i  (chain[k]),
				.pix_o  (chain[k+1])
			);
		end
	end

	bgps_shade #(.WEIGHT_TABLE_DEPTH(WEIGHT_TABLE_DEPTH)) u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.pix_i     (chain[SAMPLE_COUNT]),
		.color     (color_q),
		.out_valid (m_tvalid),
		.out_rgb   (m_tdata)
	);

endmodule

@@ hdl/bgps_build.sv @@
// Curve sample builder: evaluates the cubic Bezier at each sample point with four
// multiply-accumulate steps per coordinate, divides by reciprocal multiplication
// with a compare and subtract fix-up, and loads samples into the cell chain. Depends on bgps_pkg.
module bgps_build import bgps_pkg::*; #(
	parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             restart,
	input  logic [3:0][31:0] cp,
	output smp_load_t        smp,
	output logic             ready
);

	localparam int IW = (SAMPLE_COUNT > 2) ? $clog2(SAMPLE_COUNT) : 1;
	localparam longint unsigned N  = SAMPLE_COUNT - 1;
	localparam longint unsigned N3 = N * N * N;
	localparam int CW = (N3 > 1) ? $clog2(N3 + 1) : 1;
	localparam int AW = CW + 16;
	localparam int PW = 3 * IW + 2;
	// Reciprocal of N3: the top 32 bits of the sum times RECIP, shifted by K, land
	// at most one below the true quotient
	localparam int SH = (AW > 32) ? AW - 32 : 0;
	localparam int K  = 30 + CW - SH;
	localparam longint unsigned RECIP = (64'd1 << (SH + K)) / N3;

	localparam logic [2:0] ST_SQ   = 3'd0;
	localparam logic [2:0] ST_CF   = 3'd1;
	localparam logic [2:0] ST_MAC  = 3'd2;
	localparam logic [2:0] ST_QE   = 3'd3;
	localparam logic [2:0] ST_RM   = 3'd4;
	localparam logic [2:0] ST_FX   = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]      st_q;
	logic [IW-1:0]   i_q;
	logic [1:0]      j_q;
	logic            coord_q;
	logic [2*IW-1:0] uu_q;
	logic [2*IW-1:0] ii_q;
	logic [CW-1:0]   cf_q;
	logic [AW-1:0]   acc_q;
	logic [AW-1:0]   rem_q;
	logic [15:0]     q_q;
	logic [15:0]     x_q;
	logic            ready_q;
	logic            load_q;
	logic [31:0]     sample_q;

	logic [IW-1:0]   u;
	logic [2*IW-1:0] cf_a;
	logic [IW-1:0]   cf_b;
	logic [PW-1:0]   cf_m;
	logic [PW-1:0]   cf_v;
	logic [15:0]     coef_p;
	logic [31:0]     a_t;
	logic [63:0]     qe_m;
	logic            fix_ge;

	// Pick the coefficient operands and the control point coordinate
	always_comb begin
		u      = IW'(N) - i_q;
		cf_a   = j_q[1] ? ii_q : uu_q;
		cf_b   = j_q[0] ? i_q : u;
		cf_m   = PW'(cf_a) * PW'(cf_b);
		cf_v   = (j_q == 2'd1 || j_q == 2'd2) ? (cf_m + (cf_m << 1)) : cf_m;
		coef_p = coord_q ? cp[j_q][15:0] : cp[j_q][31:16];
		a_t    = 32'(acc_q >> SH);
		qe_m   = 64'(a_t) * 64'(RECIP);
		fix_ge = (rem_q >= AW'(N3));
	end

	// Sequence coefficients, accumulation and the quotient estimate and fix-up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_SQ;
			i_q     <= '0;
			ready_q <= 1'b0;
			load_q  <= 1'b0;
		end else begin
			load_q <= 1'b0;
			if (restart) begin
				st_q    <= ST_SQ;
				i_q     <= '0;
				ready_q <= 1'b0;
			end else begin
				case (st_q)
					ST_SQ: begin
						st_q <= ST_CF;
					end
					ST_CF: begin
						st_q <= ST_MAC;
					end
					ST_MAC: begin
						if (j_q == 2'd3) st_q <= ST_QE;
						else st_q <= ST_CF;
					end
					ST_QE: begin
						st_q <= ST_RM;
					end
					ST_RM: begin
						st_q <= ST_FX;
					end
					ST_FX: begin
						if (!fix_ge) begin
							if (!coord_q) begin
								st_q <= ST_CF;
							end else begin
								load_q <= 1'b1;
								if (i_q == IW'(N)) begin
									ready_q <= 1'b1;
									st_q    <= ST_DONE;
								end else begin
									i_q  <= i_q + 1'b1;
									st_q <= ST_SQ;
								end
							end
						end
					end
					ST_DONE: begin
						st_q <= ST_DONE;
					end
					default: begin
						st_q <= ST_SQ;
					end
				endcase
			end
		end
	end

	// Datapath registers of the sequencer
	always_ff @(posedge clk) begin
		case (st_q)
			ST_SQ: begin
				uu_q    <= (2*IW)'(u) * (2*IW)'(u);
				ii_q    <= (2*IW)'(i_q) * (2*IW)'(i_q);
				j_q     <= 2'd0;
				coord_q <= 1'b0;
				acc_q   <= AW'(N3 / 2);
			end
			ST_CF: begin
				cf_q <= CW'(cf_v);
			end
			ST_MAC: begin
				acc_q <= acc_q + AW'(cf_q) * AW'(coef_p);
				j_q   <= j_q + 1'b1;
			end
			ST_QE: begin
				q_q <= 16'(qe_m >> K);
			end
			ST_RM: begin
				rem_q <= acc_q - AW'(q_q) * AW'(N3);
			end
			ST_FX: begin
				if (fix_ge) begin
					rem_q <= rem_q - AW'(N3);
					q_q   <= q_q + 1'b1;
				end else if (!coord_q) begin
					x_q     <= q_q;
					coord_q <= 1'b1;
					j_q     <= 2'd0;
					acc_q   <= AW'(N3 / 2);
				end else begin
					sample_q <= {x_q, q_q};
				end
			end
			default: begin
			end
		endcase
	end

	// Open input only after the last sample has shifted into the chain
	assign smp.load   = load_q;
	assign smp.sample = sample_q;
	assign ready      = ready_q && !load_q;

endmodule

@@ hdl/bgps_cell.sv @@
// One chain cell: holds one curve sample, folds it into the running minimum
// squared distance of the passing pixel. Depends on bgps_pkg.
module bgps_cell import bgps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        load,
	input  logic [31:0] smp_i,
	output logic [31:0] smp_o,
	input  pix_t        pix_i,
	output pix_t        pix_o
);

	logic [31:0] sample_q;
	logic        valid_s1;
	logic [15:0] px_s1;
	logic [15:0] py_s1;
	logic [32:0] best_s1;
	logic [31:0] dx2_s1;
	logic [31:0] dy2_s1;
	logic        valid_s2;
	logic [15:0] px_s2;
	logic [15:0] py_s2;
	logic [32:0] best_s2;

	logic [16:0] dx;
	logic [16:0] dy;
	logic [15:0] adx;
	logic [15:0] ady;
	logic [32:0] d2;

	// Shift samples down the chain while building
	always_ff @(posedge clk) begin
		if (load) sample_q <= smp_i;
	end

	// Absolute coordinate differences and sum of squares
	always_comb begin
		dx  = {1'b0, pix_i.px} - {1'b0, sample_q[31:16]};
		dy  = {1'b0, pix_i.py} - {1'b0, sample_q[15:0]};
		adx = dx[16] ? 16'(-dx) : dx[15:0];
		ady = dy[16] ? 16'(-dy) : dy[15:0];
		d2  = 33'(dx2_s1) + 33'(dy2_s1);
	end

	// Hold valid bits across stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pix_i.valid;
			valid_s2 <= valid_s1;
		end
	end

	// Square, then compare against the running minimum
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= pix_i.px;
			py_s1   <= pix_i.py;
			best_s1 <= pix_i.best;
			dx2_s1  <= 32'(adx) * 32'(adx);
			dy2_s1  <= 32'(ady) * 32'(ady);
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			best_s2 <= (d2 < best_s1) ? d2 : best_s1;
		end
	end

	assign smp_o       = sample_q;
	assign pix_o.valid = valid_s2;
	assign pix_o.px    = px_s2;
	assign pix_o.py    = py_s2;
	assign pix_o.best  = best_s2;

endmodule

@@ hdl/bgps_shade.sv @@
// Shading pipeline: weight lookup, color blend, glow, gain, clamp and 8-bit
// conversion, ending in the output register. Depends on bgps_pkg.
module bgps_shade import bgps_pkg::*; #(
	parameter int WEIGHT_TABLE_DEPTH = WTAB_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  pix_t        pix_i,
	input  logic [47:0] color,
	output logic        out_valid,
	output logic [23:0] out_rgb
);

	localparam int TW = $clog2(WEIGHT_TABLE_DEPTH);
	localparam int DW = $clog2(WEIGHT_TABLE_DEPTH + 1);
	localparam longint unsigned WSTEP = (64'd625 << 27) / WEIGHT_TABLE_DEPTH;
	localparam longint unsigned WRATIO = wrom_ratio(WSTEP);

	logic [16:0] wtab [WEIGHT_TABLE_DEPTH];

	// Gaussian weight table
	for (genvar k = 0; k < WEIGHT_TABLE_DEPTH; k++) begin : g_wtab
		localparam logic [16:0] WENT = wrom_entry(k, WRATIO);
		assign wtab[k] = WENT;
	end

	logic [29+DW:0] iprod;
	logic [6:0]     valid_q;
	logic           far_s1;
	logic [TW-1:0]  idx_s1;
	logic [16:0]    w_s2;
	logic [16:0]    fac_s3;
	logic [16:0]    fac_s4;

	assign iprod = (30+DW)'(pix_i.best[29:0]) * (30+DW)'(WEIGHT_TABLE_DEPTH);

	// Advance valid bits with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[5:0], pix_i.valid};
		end
	end

	// Table index, weight and glow factor
	always_ff @(posedge clk) begin
		if (en) begin
			far_s1 <= (pix_i.best[32:30] != 3'd0);
			idx_s1 <= iprod[29+TW:30];
			w_s2   <= far_s1 ? 17'd0 : wtab[idx_s1];
			fac_s3 <= ONE_Q16 + ((ONE_Q16 - w_s2) >> 1);
			fac_s4 <= fac_s3;
		end
	end

	// One lane per color channel
	for (genvar c = 0; c < 3; c++) begin : g_lane
		logic [15:0] cc;
		logic [32:0] ma_s3;
		logic [30:0] mb_s3;
		logic [33:0] msum;
		logic [16:0] mix_s4;
		logic [33:0] t_s5;
		logic [50:0] vw;
		logic [16:0] v_s6;
		logic [40:0] ow;
		logic [7:0]  out_q;

		assign cc   = color[47-16*c -: 16];
		assign msum = 34'(ma_s3) + 34'(mb_s3) + 34'd32768;
		assign vw   = 51'(t_s5) * 51'(GAIN[c]) + 51'h8000_0000;
		assign ow   = 41'(v_s6) * 41'(OUT_SCALE);

		// Blend, glow, gain, clamp and scale
		always_ff @(posedge clk) begin
			if (en) begin
				ma_s3  <= 33'(cc) * 33'(w_s2);
				mb_s3  <= 31'(BG_LEVEL[c]) * 31'(ONE_Q16 - w_s2);
				mix_s4 <= msum[32:16];
				t_s5   <= 34'(mix_s4) * 34'(fac_s4);
				v_s6   <= (vw[50:32] > 19'(ONE_Q16)) ? ONE_Q16 : vw[48:32];
				out_q  <= ow[39:32];
			end
		end

		assign out_rgb[8*c +: 8] = out_q;
	end

	assign out_valid = valid_q[6];

endmodule

@@ hdl/bgps_chk.sv @@
// Port-level checks for the Bezier glow pixel shader, bound to the top level.
// Depends on bgps_pkg and bezier_glow_pixel_shader.
module bgps_chk import bgps_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [31:0]          s_tdata,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [23:0]          m_tdata,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [47:0]          cfg_data
);

	// No result shows while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// A stalled result transaction holds its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result dropped or changed");

	// A stalled output stops input
	a_stall_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	// A control point write closes input until samples are rebuilt
	a_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index >= REG_CP0) && (cfg_index <= REG_CP3)
		|=> !s_tready)
		else $error("input open right after control point write");

endmodule

bind bezier_glow_pixel_shader bgps_chk u_chk (.*);

@@ sim/tb_bezier_glow_pixel_shader.sv @@
// Self-checking testbench for bezier_glow_pixel_shader: directed table, then random pixels
// near and away from the configured curve. Depends on bgps_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_bezier_glow_pixel_shader;
	import bgps_pkg::*;

	localparam int NSAMP       = SAMPLE_COUNT_DEF;
	localparam int WDEPTH      = WTAB_DEPTH_DEF;
	localparam int DRAIN_SLACK = 2 * NSAMP + 80;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int PHASE_ITEMS = 280;
	localparam int NUM_PHASES  = 6;

	localparam logic [CFG_IDX_W-1:0] REG_CP1     = REG_CP0 + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CP2     = REG_CP0 + 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOGUS_A = REG_COLOR + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOGUS_B = '1;

	typedef enum logic { ROW_CFG, ROW_PIX } row_kind_e;

	typedef struct {
		row_kind_e            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [47:0]          data;
		logic [15:0]          px;
		logic [15:0]          py;
		bit                   typed;
		logic [23:0]          rgb;   // blue, green, red
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [31:0]          s_tdata;   // pixel_x [15:0], pixel_y [31:16]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [23:0]          m_tdata;   // red [7:0], green [15:8], blue [23:16]
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [47:0]          cfg_data;

	// Shadow of the block's configuration and derived tables
	logic [31:0]          shadow_cp [0:3];
	logic [47:0]          shadow_color;
	int unsigned          curve_x [0:NSAMP-1];
	int unsigned          curve_y [0:NSAMP-1];
	int unsigned          glow_weight [0:WDEPTH-1];

	logic [23:0]          rgb_pending [$];
	int                   mismatches;
	int                   strays;
	int                   pixels_sent;
	int                   pixels_checked;
	int                   cfg_writes;
	bit                   idle_en;
	bit                   hold_req;
	int                   rx_hold;
	longint               cycles;

	bezier_glow_pixel_shader u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Gaussian weight ROM: successive Q32 products of exp(-step), rounded to Q16
	function automatic void build_glow_weights();
		longint unsigned step_q, s, term, sum, ratio, acc;
		step_q = (longint'(625) << 27) / WDEPTH;
		s = step_q >> 4;
		term = 64'h1_0000_0000;
		sum = 64'h1_0000_0000;
		for (int n = 1; n <= 8; n++) begin
			term = ((term * s) >> 32) / longint'(n);
			if (n % 2 == 1) sum = sum - term;
			else sum = sum + term;
		end
		ratio = sum;
		for (int n = 0; n < 4; n++)
			ratio = (ratio * ratio + 64'h8000_0000) >> 32;
		acc = 64'h1_0000_0000;
		for (int k = 0; k < WDEPTH; k++) begin
			glow_weight[k] = int'((acc + 64'd32768) >> 16);
			acc = (acc * ratio + 64'h8000_0000) >> 32;
		end
	endfunction

	// Resample the cubic at t = i/(N-1), exact integer Bernstein blend, rounded
	function automatic void resample_curve();
		longint unsigned n, n3, u, ax, ay;
		longint unsigned cf [0:3];
		n = NSAMP - 1;
		n3 = n * n * n;
		for (int i = 0; i < NSAMP; i++) begin
			u = n - longint'(i);
			cf[0] = u * u * u;
			cf[1] = 3 * u * u * longint'(i);
			cf[2] = 3 * u * longint'(i) * longint'(i);
			cf[3] = longint'(i) * longint'(i) * longint'(i);
			ax = n3 / 2;
			ay = n3 / 2;
			for (int j = 0; j < 4; j++) begin
				ax += cf[j] * longint'(shadow_cp[j][31:16]);
				ay += cf[j] * longint'(shadow_cp[j][15:0]);
			end
			curve_x[i] = int'(ax / n3);
			curve_y[i] = int'(ay / n3);
		end
	endfunction

	// Expected RGB for one pixel: nearest sample, glow weight, blend, glow, gain
	function automatic logic [23:0] shade_pixel(logic [15:0] px, logic [15:0] py);
		longint best, dx, dy, d2;
		longint unsigned w, glow, mix, v, col, bg, gain;
		logic [23:0] rgb;
		best = 64'h1_0000_0000;
		for (int k = 0; k < NSAMP; k++) begin
			dx = longint'(px) - longint'(curve_x[k]);
			dy = longint'(py) - longint'(curve_y[k]);
			d2 = dx * dx + dy * dy;
			if (d2 < best) best = d2;
		end
		w = 0;
		if (best < (longint'(1) << 30)) w = glow_weight[(best * WDEPTH) >> 30];
		if (w > 65536) w = 65536;
		glow = 65536 + ((65536 - w) >> 1);
		for (int ch = 0; ch < 3; ch++) begin
			col = shadow_color[47 - 16 * ch -: 16];
			bg = (ch == 2) ? 9830 : 3277;
			gain = (ch == 0) ? 65536 : ((ch == 1) ? 78643 : 98304);
			mix = (bg * (65536 - w) + col * w + 32768) >> 16;
			v = (mix * glow * gain + 64'h8000_0000) >> 32;
			if (v > 65536) v = 65536;
			rgb[8 * ch +: 8] = 8'((v * 16777150) >> 32);
		end
		return rgb;
	endfunction

	// Write one register; update the shadow on the transaction
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_writes++;
		if (idx <= REG_CP3) begin
			shadow_cp[idx] = data[31:0];
			resample_curve();
		end else if (idx == REG_COLOR) begin
			shadow_color = data;
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one pixel, with an optional idle burst first; predict on the transaction
	task automatic send_pixel(logic [15:0] px, logic [15:0] py, bit typed, logic [23:0] rgb);
		if (idle_en && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {py, px};
		do @(posedge clk); while (!s_tready);
		rgb_pending.push_back(typed ? rgb : shade_pixel(px, py));
		pixels_sent++;
	endtask

	// Stop offering, let every pixel come back, then let the chain settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (rgb_pending.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// Receiver: check each transaction, stall in bursts, honor a long hold-off
	initial begin
		logic [23:0] want;
		m_tready = 1'b0;
		rx_hold = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (rgb_pending.size() == 0) begin
					strays++;
					if (strays + mismatches <= 10)
						$display("unexpected pixel out: %h", m_tdata);
				end else begin
					want = rgb_pending.pop_front();
					pixels_checked++;
					if (m_tdata !== want) begin
						mismatches++;
						if (strays + mismatches <= 10)
							$display("pixel %0d: want r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
								pixels_checked, want[7:0], want[15:8], want[23:16],
								m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]);
					end
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				rx_hold = 3 * NSAMP + 700;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 15) == 0) begin
				rx_hold = $urandom_range(1, 17) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	// Main sequence
	initial begin
		dir_row_t rows [24];
		logic [15:0] px, py;
		int k;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		strays = 0;
		pixels_sent = 0;
		pixels_checked = 0;
		cfg_writes = 0;
		idle_en = 1'b1;
		hold_req = 1'b0;
		for (int j = 0; j < 4; j++) shadow_cp[j] = '0;
		shadow_color = '0;
		build_glow_weights();
		resample_curve();

		rows = '{
			// all samples at the origin, black curve color
			'{ROW_PIX, REG_CP0, 48'h0, 16'h0000, 16'h0000, 1'b1, 24'h000000},
			'{ROW_PIX, REG_CP0, 48'h0, 16'hFFFF, 16'hFFFF, 1'b0, 24'h0},  // capped distance
			'{ROW_PIX, REG_CP0, 48'h0, 16'h4000, 16'h0000, 1'b0, 24'h0},
			'{ROW_PIX, REG_CP0, 48'h0, 16'h8000, 16'h0000, 1'b0, 24'h0},  // exactly one quarter
			'{ROW_PIX, REG_CP0, 48'h0, 16'h7FFF, 16'h0000, 1'b0, 24'h0},  // just inside
			'{ROW_CFG, REG_COLOR, 48'hFFFF_FFFF_FFFF, 16'h0, 16'h0, 1'b0, 24'h0},
			'{ROW_PIX, REG_CP0, 48'h0, 16'h0000, 16'h0000, 1'b1, 24'hFFFFFF},
			// stray high bits of a control point are dropped
			'{ROW_CFG, REG_CP0, 48'hFFFF_0000_0000, 16'h0, 16'h0, 1'b0, 24'h0},
			'{ROW_PIX, REG_CP0, 48'h0, 16'h0000, 16'h0000, 1'b1, 24'hFFFFFF},
			// unused register indexes change nothing
			'{ROW_CFG, REG_BOGUS_A, 48'h1234_5678_9ABC, 16'h0, 16'h0, 1'b0, 24'h0},
			'{ROW_CFG, REG_BOGUS_B, 48'hFFFF_FFFF_FFFF, 16'h0, 16'h0, 1'b0, 24'h0},
			'{ROW_CFG, REG_CP0, 48'h0000_0000_0000, 16'h0, 16'h0, 1'b0, 24'h0},
			'{ROW_CFG, REG_CP1, 48'h0000_0000_FFFF, 16'h0, 16'h0, 1'b0, 24'h0},
			'{ROW_CFG, REG_CP2, 48'h0000_FFFF_FFFF, 16'h0, 16'h0, 1'b0, 24'h0},
			'{ROW_CFG, REG_CP3, 48'h0000_FFFF_0000, 16'h0, 16'h0, 1'b0, 24'h0},
			'{ROW_CFG, REG_COLOR, 48'h1234_8000_FFFF, 16'h0, 16'h0, 1'b0, 24'h0},
			'{ROW_PIX, REG_CP0, 48'h0, 16'h0000, 16'h0000, 1'b0, 24'h0},
			'{ROW_PIX, REG_CP0, 48'h0, 16'hFFFF, 16'hFFFF, 1'b0, 24'h0},
			'{ROW_PIX, REG_CP0, 48'h0, 16'h8000, 16'h8000, 1'b0, 24'h0},
			'{ROW_PIX, REG_CP0, 48'h0, 16'h8000, 16'h0000, 1'b0, 24'h0},
			'{ROW_PIX, REG_CP0, 48'h0, 16'h0000, 16'h8000, 1'b0, 24'h0},
			'{ROW_PIX, REG_CP0, 48'h0, 16'hFFFF, 16'h0000, 1'b0, 24'h0},
			'{ROW_CFG, REG_COLOR, 48'h0, 16'h0, 16'h0, 1'b0, 24'h0},
			'{ROW_PIX, REG_CP0, 48'h0, 16'h8000, 16'h8000, 1'b0, 24'h0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; drain before every register write
		foreach (rows[r]) begin
			if (rows[r].kind == ROW_CFG) begin
				drain();
				write_reg(rows[r].idx, rows[r].data);
			end else begin
				send_pixel(rows[r].px, rows[r].py, rows[r].typed, rows[r].rgb);
			end
		end

		// Random phases, each with fresh control points and color
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			if (p == NUM_PHASES - 1) idle_en = 1'b0;
			for (int j = 0; j < 4; j++) begin
				case (p)
					1: write_reg(REG_CP0 + 3'(j), 48'hFFFF_FFFF_FFFF);
					2: write_reg(REG_CP0 + 3'(j), 48'h0);
					default: write_reg(REG_CP0 + 3'(j), {16'($urandom), 32'($urandom)});
				endcase
			end
			write_reg(REG_COLOR, (p == 1) ? 48'hFFFF_FFFF_FFFF :
				{16'($urandom), 32'($urandom)});
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 3 && i == 40) hold_req = 1'b1;
				if ($urandom_range(0, 9) < 7) begin
					// near a sample so the glow weight is nonzero
					k = $urandom_range(0, NSAMP - 1);
					px = 16'(curve_x[k] + $urandom_range(0, 16'h1800) - 16'h0C00);
					py = 16'(curve_y[k] + $urandom_range(0, 16'h1800) - 16'h0C00);
				end else begin
					px = 16'($urandom);
					py = 16'($urandom);
				end
				send_pixel(px, py, 1'b0, 24'h0);
			end
		end

		drain();
		$display("%0d pixels checked over %0d register writes, %0d curve settings",
			pixels_checked, cfg_writes, NUM_PHASES + 2);
		$display("%0d mismatches, %0d unexpected pixels", mismatches, strays);
		if (mismatches == 0 && strays == 0 && rgb_pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
